@@ sv/rtspdf_pkg.sv @@
// ----------------------------------------------------------------------------
// rtspdf_pkg
// Shared types and constants for the interleaved RTSP deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtspdf_pkg;

  // Default number of streams that map onto channel pairs
  localparam int unsigned STREAM_COUNT_DEF = 2;

  localparam logic [7:0] MARK_BYTE = 8'h24;  // '$' opens a channel frame
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;

  // Deframer phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_CHAN    = 5'b00010,
    PH_LENHI   = 5'b00100,
    PH_LENLO   = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Double-CRLF matcher step result
  typedef struct packed {
    logic [1:0] match;  // characters of CR LF CR LF matched so far
    logic       done;   // this byte completed the sequence
  } crlf_t;

endpackage

`default_nettype wire

@@ sv/rtsp_interleaved_deframer.sv @@
// ----------------------------------------------------------------------------
// rtsp_interleaved_deframer
// Splits an RTSP-over-TCP byte stream into text bytes and interleaved
// channel payload bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the input channel while in_ready is high and
// gives at most one tagged item per byte on the output channel. The byte is
// decoded in the accept cycle and its item lands in the output register on
// the next edge, so a steady stream runs at one byte per clock as long as the
// sink keeps out_ready high. The input stalls only while a finished item sits
// in the output register and the sink is not taking it. In interleaved mode a
// '$' (0x24) between RTSP messages opens a four-byte header ('$', channel,
// 16-bit big-endian length); header bytes give no item, and a zero length
// gives one item with empty_payload set. Everything else is RTSP text, with
// last_byte marking the LF that completes a double CRLF. interleaved_mode
// resets to 1 and should be changed only while the block is idle; a frame in
// progress always runs to its end regardless of the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_interleaved_deframer #(
  parameter int unsigned STREAM_COUNT = rtspdf_pkg::STREAM_COUNT_DEF  // 1..128
) (
  input  wire  logic       clk,
  input  wire  logic       rst,
  // config
  input  wire  logic       cfg_we,
  input  wire  logic       cfg_wdata,
  // byte input
  input  wire  logic       in_valid,
  output logic             in_ready,
  input  wire  logic [7:0] data_byte,
  // tagged output
  output logic             out_valid,
  input  wire  logic       out_ready,
  output logic [7:0]       out_byte,
  output logic             is_rtsp,
  output logic [7:0]       channel_id,
  output logic [6:0]       stream_index,
  output logic             stream_valid,
  output logic             first_byte,
  output logic             last_byte,
  output logic             empty_payload
);

  // stream_valid threshold, sized to compare against a zero-extended index
  localparam logic [7:0] STREAM_LIMIT = 8'(STREAM_COUNT);

  // control state
  logic                 interleaved_mode;
  rtspdf_pkg::phase_t   phase, phase_next;
  logic [7:0]           channel_reg, channel_reg_next;
  logic [15:0]          remaining_count, remaining_count_next;
  logic [1:0]           crlf_match, crlf_match_next;
  logic                 at_start, at_start_next;

  rtspdf_pkg::crlf_t    crlf_step;

  // result of the byte being accepted
  logic                 res_valid;
  logic [7:0]           res_byte;
  logic                 res_rtsp;
  logic                 res_first;
  logic                 res_last;
  logic                 res_empty;
  logic [7:0]           res_chan;

  logic                 in_fire;
  logic [15:0]          len_full;
  logic [15:0]          rem_dec;

  // Output register is free or being emptied this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign len_full = {remaining_count[15:8], data_byte};
  assign rem_dec  = remaining_count - 16'd1;

  rtspdf_crlf u_crlf (
    .match     (crlf_match),
    .data_byte (data_byte),
    .step      (crlf_step)
  );

  always_comb begin
    phase_next           = phase;
    channel_reg_next     = channel_reg;
    remaining_count_next = remaining_count;
    crlf_match_next      = crlf_match;
    at_start_next        = at_start;
    res_valid            = 1'b0;
    res_byte             = data_byte;
    res_rtsp             = 1'b0;
    res_first            = 1'b0;
    res_last             = 1'b0;
    res_empty            = 1'b0;
    case (phase)
      rtspdf_pkg::PH_CHAN: begin
        channel_reg_next = data_byte;
        phase_next       = rtspdf_pkg::PH_LENHI;
      end
      rtspdf_pkg::PH_LENHI: begin
        remaining_count_next = {data_byte, 8'h00};
        phase_next           = rtspdf_pkg::PH_LENLO;
      end
      rtspdf_pkg::PH_LENLO: begin
        remaining_count_next = len_full;
        at_start_next        = 1'b1;
        if (len_full == 16'd0) begin
          // zero-length frame: one empty item, back to idle
          res_valid  = 1'b1;
          res_byte   = 8'h00;
          res_first  = 1'b1;
          res_last   = 1'b1;
          res_empty  = 1'b1;
          phase_next = rtspdf_pkg::PH_IDLE;
        end else begin
          phase_next = rtspdf_pkg::PH_PAYLOAD;
        end
      end
      rtspdf_pkg::PH_PAYLOAD: begin
        remaining_count_next = rem_dec;
        res_valid            = 1'b1;
        res_first            = at_start;
        res_last             = (rem_dec == 16'd0);
        at_start_next        = res_last;
        if (res_last) begin
          phase_next = rtspdf_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = rtspdf_pkg::PH_IDLE;
        if (interleaved_mode && at_start && (data_byte == rtspdf_pkg::MARK_BYTE)) begin
          // frame mark between messages
          phase_next      = rtspdf_pkg::PH_CHAN;
          crlf_match_next = 2'd0;
        end else begin
          res_valid       = 1'b1;
          res_rtsp        = 1'b1;
          res_first       = at_start;
          res_last        = crlf_step.done;
          crlf_match_next = crlf_step.match;
          at_start_next   = crlf_step.done;
        end
      end
    endcase
  end

  // text items carry no channel tag
  assign res_chan = res_rtsp ? 8'h00 : channel_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      interleaved_mode <= 1'b1;
    end else if (cfg_we) begin
      interleaved_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= rtspdf_pkg::PH_IDLE;
      channel_reg     <= 8'h00;
      remaining_count <= 16'h0000;
      crlf_match      <= 2'd0;
      at_start        <= 1'b1;
    end else if (in_fire) begin
      phase           <= phase_next;
      channel_reg     <= channel_reg_next;
      remaining_count <= remaining_count_next;
      crlf_match      <= crlf_match_next;
      at_start        <= at_start_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_byte      <= res_byte;
      is_rtsp       <= res_rtsp;
      channel_id    <= res_chan;
      stream_index  <= res_chan[7:1];
      stream_valid  <= !res_rtsp && ({1'b0, res_chan[7:1]} < STREAM_LIMIT);
      first_byte    <= res_first;
      last_byte     <= res_last;
      empty_payload <= res_empty;
    end
  end

endmodule

`default_nettype wire

@@ sv/rtspdf_crlf.sv @@
// ----------------------------------------------------------------------------
// rtspdf_crlf
// Next-state logic of the double-CRLF end-of-message matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module rtspdf_crlf (
  input  wire logic [1:0]         match,
  input  wire logic [7:0]         data_byte,
  output rtspdf_pkg::crlf_t       step
);

  logic is_cr;
  logic is_lf;

  assign is_cr = (data_byte == rtspdf_pkg::CR_BYTE);
  assign is_lf = (data_byte == rtspdf_pkg::LF_BYTE);

  always_comb begin
    step.done  = 1'b0;
    step.match = is_cr ? 2'd1 : 2'd0;
    case (match)
      2'd1: begin
        if (is_lf) begin
          step.match = 2'd2;
        end
      end
      2'd2: begin
        step.match = is_cr ? 2'd3 : 2'd0;
      end
      2'd3: begin
        if (is_lf) begin
          step.done  = 1'b1;
          step.match = 2'd0;
        end
      end
      default: begin
        step.match = is_cr ? 2'd1 : 2'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/rtspdf_checker.sv @@
// ----------------------------------------------------------------------------
// rtspdf_checker
// Port-level checks on the interleaved RTSP deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtspdf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       is_rtsp,
  input wire logic [7:0] channel_id,
  input wire logic [6:0] stream_index,
  input wire logic       stream_valid,
  input wire logic       first_byte,
  input wire logic       last_byte,
  input wire logic       empty_payload
);

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_rtsp)
      && $stable(channel_id) && $stable(first_byte) && $stable(last_byte))
    else $error("output item changed while stalled");

  // input never blocked with an empty output register
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // empty frame item is a whole one-item channel packet
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_payload |-> first_byte && last_byte && !is_rtsp
      && (out_byte == 8'h00))
    else $error("malformed empty-payload item");

  // text items carry no channel tag
  a_text_untagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_rtsp |-> (channel_id == 8'h00) && !stream_valid && !empty_payload)
    else $error("text item carries channel tag");

  // stream index follows the channel pair
  a_stream_map: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stream_index == channel_id[7:1])
    else $error("stream index does not match channel");

endmodule

bind rtsp_interleaved_deframer rtspdf_checker u_rtspdf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .is_rtsp       (is_rtsp),
  .channel_id    (channel_id),
  .stream_index  (stream_index),
  .stream_valid  (stream_valid),
  .first_byte    (first_byte),
  .last_byte     (last_byte),
  .empty_payload (empty_payload)
);

`default_nettype wire
